### hw/rtl/lsps_pkg.sv
// Shared types, register indexes and decode helpers for the line sensor PID steering unit.
// No dependencies; imported by line_sensor_pid_steering_unit.
`timescale 1ns / 1ps
`default_nettype none

package lsps_pkg;

  localparam int unsigned SensW   = 5;
  localparam int unsigned ErrW    = 4;
  localparam int unsigned SpeedW  = 9;
  localparam int unsigned GainW   = 16;
  localparam int unsigned BaseW   = 8;
  localparam int unsigned PwmW    = 6;
  localparam int unsigned JuncW   = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_BASE_SPEED = 3'd3,
    REG_PWM_GAIN   = 3'd4,
    REG_STOP_JUNC  = 3'd5
  } lsps_reg_t;

  typedef enum logic [JuncW-1:0] {
    JUNC_NONE  = 2'd0,
    JUNC_FRONT = 2'd1,
    JUNC_LEFT  = 2'd2,
    JUNC_RIGHT = 2'd3
  } lsps_junc_t;

  typedef struct packed {
    logic                   follow;  // recognised on-line pattern
    logic                   lost;    // all sensors off the line
    logic signed [ErrW-1:0] err;
  } lsps_dec_t;

  // Sensor pattern to position error; a 0 bit means the line is seen
  function automatic lsps_dec_t lsps_decode(input logic [SensW-1:0] s);
    lsps_dec_t d;
    d = '{follow: 1'b1, lost: 1'b0, err: 4'sd0};
    case (s)
      5'd15:   d.err = 4'sd4;
      5'd7:    d.err = 4'sd3;
      5'd23:   d.err = 4'sd2;
      5'd19:   d.err = 4'sd1;
      5'd27:   d.err = 4'sd0;
      5'd25:   d.err = -4'sd1;
      5'd29:   d.err = -4'sd2;
      5'd28:   d.err = -4'sd3;
      5'd30:   d.err = -4'sd4;
      5'd31:   d = '{follow: 1'b0, lost: 1'b1, err: 4'sd0};
      default: d = '{follow: 1'b0, lost: 1'b0, err: 4'sd0};
    endcase
    return d;
  endfunction

  // Front beats left beats right
  function automatic lsps_junc_t lsps_junction(input logic [SensW-1:0] s);
    lsps_junc_t j;
    if (!s[0] && !s[4])      j = JUNC_FRONT;
    else if (!s[0] && !s[1]) j = JUNC_LEFT;
    else if (!s[3] && !s[4]) j = JUNC_RIGHT;
    else                     j = JUNC_NONE;
    return j;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/line_sensor_pid_steering_unit.sv
// Line sensor PID steering unit: sensor decode, PID on one shared multiplier, speed clamp.
// Depends on lsps_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel (in_valid/in_ready/in_sensors): one five-bit sensor sample per
//   transaction. Output channel (out_valid/out_ready/out_*): one result per sample,
//   in order. Configuration: cfg_we writes cfg_wdata into the register picked by
//   cfg_index on that edge; unknown indexes are ignored. Write only while idle.
//   Timing: the sample is decoded in the accept cycle, then a sequencer runs the
//   single 33x17 multiplier four times (P, I, D terms, then the PWM scale) and a
//   shared truncate-and-clamp unit twice (left, right). An on-line sample passes
//   through all of these steps before its result step; a line-lost sample goes
//   straight to the result step. One sample is in work at a time, so a new
//   sample is taken only once the sequencer is back in its idle step.
//   The result sits in an output register; in_ready rises again as soon as
//   that register is loaded, so the next sample can be taken while the receiver
//   stalls. If the previous result is still unclaimed, the sequencer waits in
//   its final step until out_ready frees the register.
//   Reset (rst_n low, synchronous) restores the default gains and clears the
//   held error, integral, prior error, mode and last speeds; no output is valid.

module line_sensor_pid_steering_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic [lsps_pkg::CfgIdxW-1:0]         cfg_index,
  input  wire logic [lsps_pkg::CfgDatW-1:0]         cfg_wdata,
  // sensor samples
  input  wire logic                                 in_valid,
  output      logic                                 in_ready,
  input  wire logic [lsps_pkg::SensW-1:0]           in_sensors,
  // results
  output      logic                                 out_valid,
  input  wire logic                                 out_ready,
  output      logic signed [lsps_pkg::SpeedW-1:0]   out_left_speed,
  output      logic signed [lsps_pkg::SpeedW-1:0]   out_right_speed,
  output      logic signed [lsps_pkg::ErrW-1:0]     out_position_error,
  output      logic                                 out_line_lost,
  output      logic [lsps_pkg::JuncW-1:0]           out_junction_kind,
  output      logic                                 out_stop_reached
);

  import lsps_pkg::*;

  localparam int unsigned AccW  = 33;  // |P+I+D| < 2^31
  localparam int unsigned MulBW = 17;
  localparam int unsigned ProdW = AccW + MulBW;
  localparam int unsigned OffW  = 40;  // pid * pwm_gain < 2^37
  localparam int unsigned QW    = OffW + 1;

  // One-hot sequencer
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MUL_P = 8'b0000_0010,  // acc = kp*e, integral update
    ST_MUL_I = 8'b0000_0100,  // acc += ki*sum
    ST_MUL_D = 8'b0000_1000,  // acc += kd*(e - prior)
    ST_MUL_G = 8'b0001_0000,  // off = acc * pwm_gain
    ST_SPD_L = 8'b0010_0000,
    ST_SPD_R = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic signed [GainW-1:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [BaseW-1:0]        base_speed_r;
  logic [PwmW-1:0]         pwm_gain_r;
  logic [JuncW-1:0]        stop_junc_r;

  // Controller state
  logic signed [ErrW-1:0]   held_error_r, prior_error_r;
  logic signed [GainW-1:0]  error_sum_r;
  logic                     lost_mode_r;
  logic signed [SpeedW-1:0] last_left_r, last_right_r;
  logic [JuncW-1:0]         junc_r;
  logic                     stop_r;

  // Datapath
  logic signed [AccW-1:0]  acc_r;
  logic signed [OffW-1:0]  off_r;
  logic                    out_valid_r;

  logic                    in_acc;
  lsps_dec_t               dec;
  lsps_junc_t              junc;
  logic                    lost_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  assign dec  = lsps_decode(in_sensors);
  assign junc = lsps_junction(in_sensors);
  always_comb begin
    if (dec.follow)    lost_nxt = 1'b0;
    else if (dec.lost) lost_nxt = 1'b1;
    else               lost_nxt = lost_mode_r;
  end

  // ---- shared multiplier, operands picked by the sequencer ----
  logic signed [AccW-1:0]  mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [ErrW:0]    d_err;

  assign d_err = {held_error_r[ErrW-1], held_error_r} - {prior_error_r[ErrW-1], prior_error_r};

  always_comb begin
    unique case (state_r)
      ST_MUL_P: begin
        mul_a = AccW'(prop_gain_r);
        mul_b = MulBW'(held_error_r);
      end
      ST_MUL_I: begin
        mul_a = AccW'(integ_gain_r);
        mul_b = MulBW'(error_sum_r);
      end
      ST_MUL_D: begin
        mul_a = AccW'(deriv_gain_r);
        mul_b = MulBW'(d_err);
      end
      ST_MUL_G: begin
        mul_a = acc_r;
        mul_b = {{(MulBW-PwmW){1'b0}}, pwm_gain_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Saturating integral
  logic signed [GainW:0]   sum_wide;
  logic signed [GainW-1:0] sum_sat;

  assign sum_wide = {error_sum_r[GainW-1], error_sum_r} + (GainW+1)'(held_error_r);
  always_comb begin
    if (sum_wide[GainW] != sum_wide[GainW-1])
      sum_sat = sum_wide[GainW] ? {1'b1, {(GainW-1){1'b0}}} : {1'b0, {(GainW-1){1'b1}}};
    else
      sum_sat = sum_wide[GainW-1:0];
  end

  // ---- shared truncate-and-clamp unit, left then right ----
  logic signed [QW-1:0]      q;
  logic signed [QW-1:0]      base_q;
  logic signed [QW-8-1:0]    q_int;
  logic signed [QW-8-1:0]    base_ext;
  logic signed [SpeedW-1:0]  spd;

  assign base_q   = {{(QW-BaseW-8){1'b0}}, base_speed_r, 8'd0};
  assign q        = (state_r == ST_SPD_R) ? base_q - QW'(off_r) : base_q + QW'(off_r);
  // arithmetic shift rounds down; step back up for negative values with a fraction
  assign q_int    = q[QW-1:8] + (QW-8)'(q[QW-1] && (q[7:0] != 8'd0));
  assign base_ext = {{(QW-8-BaseW){1'b0}}, base_speed_r};

  always_comb begin
    if (q_int > base_ext)       spd = SpeedW'(base_ext);
    else if (q_int < -base_ext) spd = SpeedW'(-base_ext);
    else                        spd = q_int[SpeedW-1:0];
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = lost_nxt ? ST_DONE : ST_MUL_P;
      ST_MUL_P: state_nxt = ST_MUL_I;
      ST_MUL_I: state_nxt = ST_MUL_D;
      ST_MUL_D: state_nxt = ST_MUL_G;
      ST_MUL_G: state_nxt = ST_SPD_L;
      ST_SPD_L: state_nxt = ST_SPD_R;
      ST_SPD_R: state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  logic load_out;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      prop_gain_r   <= 16'sd1536;
      integ_gain_r  <= '0;
      deriv_gain_r  <= '0;
      base_speed_r  <= 8'd150;
      pwm_gain_r    <= 6'd10;
      stop_junc_r   <= JUNC_NONE;
      held_error_r  <= '0;
      prior_error_r <= '0;
      error_sum_r   <= '0;
      lost_mode_r   <= 1'b0;
      last_left_r   <= '0;
      last_right_r  <= '0;
      junc_r        <= JUNC_NONE;
      stop_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_PROP_GAIN:  prop_gain_r  <= cfg_wdata;
          REG_INTEG_GAIN: integ_gain_r <= cfg_wdata;
          REG_DERIV_GAIN: deriv_gain_r <= cfg_wdata;
          REG_BASE_SPEED: base_speed_r <= cfg_wdata[BaseW-1:0];
          REG_PWM_GAIN:   pwm_gain_r   <= cfg_wdata[PwmW-1:0];
          REG_STOP_JUNC:  stop_junc_r  <= cfg_wdata[JuncW-1:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        lost_mode_r <= lost_nxt;
        if (dec.follow)    held_error_r <= dec.err;
        else if (dec.lost) held_error_r <= '0;
        junc_r <= junc;
        stop_r <= (junc != JUNC_NONE) && (junc == stop_junc_r);
      end

      if (state_r == ST_MUL_P) error_sum_r   <= sum_sat;
      if (state_r == ST_MUL_D) prior_error_r <= held_error_r;
      if (state_r == ST_SPD_L) last_left_r   <= spd;
      if (state_r == ST_SPD_R) last_right_r  <= spd;

      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath and result registers, no reset
  always_ff @(posedge clk) begin
    unique case (state_r) inside
      ST_MUL_P:                   acc_r <= prod[AccW-1:0];
      ST_MUL_I, ST_MUL_D:         acc_r <= acc_r + prod[AccW-1:0];
      default: ;
    endcase
    if (state_r == ST_MUL_G) off_r <= prod[OffW-1:0];
    if (load_out) begin
      out_left_speed     <= stop_r ? '0 : last_left_r;
      out_right_speed    <= stop_r ? '0 : last_right_r;
      out_position_error <= held_error_r;
      out_line_lost      <= lost_mode_r;
      out_junction_kind  <= junc_r;
      out_stop_reached   <= stop_r;
    end
  end

  // ---- checks ----
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stop_reached |-> out_left_speed == '0 && out_right_speed == '0)
    else $error("stop reported with nonzero speed");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_position_error >= -4'sd4 && out_position_error <= 4'sd4)
    else $error("position error out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while previous one still in work");

  a_lost_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_lost |-> out_position_error == '0)
    else $error("line lost with nonzero error");

endmodule

`default_nettype wire
